FILE: design/bsoc_pkg.sv
// ----------------------------------------------------------------------------
// bsoc_pkg
// Shared types, widths and the voltage-to-percent curve for the battery
// state of charge block.
// ----------------------------------------------------------------------------
package bsoc_pkg;

  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned LEVEL_W      = 4;
  localparam int unsigned THR_W        = 4;
  localparam int unsigned PCT_W        = 7;
  localparam int unsigned MV_W         = 14;
  localparam int unsigned TABLE_POINTS = 21;
  localparam int unsigned SEG_W        = $clog2(TABLE_POINTS);
  localparam int unsigned DELTA_W      = 10;
  localparam int unsigned MAX_STEP     = 5;
  localparam int unsigned STEP_W       = $clog2(MAX_STEP + 1);
  localparam int unsigned NUM_W        = 14;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [THR_W-1:0] LOW_THR_RESET = THR_W'(1);
  localparam logic [PCT_W-1:0] PCT_FULL      = PCT_W'(100);

  localparam logic [MV_W-1:0] CURVE_MV [TABLE_POINTS] = '{
    14'd6000, 14'd6540, 14'd7220, 14'd7380, 14'd7420, 14'd7460, 14'd7500,
    14'd7540, 14'd7580, 14'd7600, 14'd7640, 14'd7700, 14'd7740, 14'd7820,
    14'd7900, 14'd7960, 14'd8040, 14'd8160, 14'd8220, 14'd8300, 14'd8400
  };

  localparam logic [PCT_W-1:0] CURVE_PCT [TABLE_POINTS] = '{
    7'd0,  7'd5,  7'd10, 7'd15, 7'd20, 7'd25, 7'd30, 7'd35, 7'd40, 7'd45,
    7'd50, 7'd55, 7'd60, 7'd65, 7'd70, 7'd75, 7'd80, 7'd85, 7'd90, 7'd95,
    7'd100
  };

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_INTERP,
    CLS_FULL
  } cls_e;

  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_INVALID = 1'b1
  } status_e;

  typedef struct packed {
    cls_e               cls;
    logic [SEG_W-1:0]   seg_lo;
    logic [DELTA_W-1:0] delta;
    logic               low_flag;
    status_e            status;
  } bsoc_item_t;

endpackage

FILE: design/bsoc_front.sv
// ----------------------------------------------------------------------------
// bsoc_front
// Accepts readings, scales the sample to pack voltage, finds the curve
// segment and pushes a classified beat into the queue. Holds the threshold.
// ----------------------------------------------------------------------------
module bsoc_front #(
  parameter int unsigned DIVIDER_RATIO = 4,
  parameter int unsigned CURVE_POINTS  = 21
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bsoc_pkg::THR_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          reading_valid_i,
  input  logic [bsoc_pkg::LEVEL_W-1:0]  battery_level_i,
  input  logic [bsoc_pkg::SAMPLE_W-1:0] sample_millivolts_i,
  input  logic                          full_i,
  output logic                          push_o,
  output bsoc_pkg::bsoc_item_t          item_o
);
  import bsoc_pkg::*;

  localparam int unsigned PACK_W  = $clog2(((2 ** SAMPLE_W) - 1) * DIVIDER_RATIO + 1);
  localparam int unsigned NUM_PTS = (CURVE_POINTS > TABLE_POINTS) ? TABLE_POINTS :
                                    (CURVE_POINTS < 2) ? 2 : CURVE_POINTS;

  logic [THR_W-1:0]   thr_q;
  logic [PACK_W-1:0]  pack;
  logic [NUM_PTS-1:0] hit;
  logic [SEG_W-1:0]   seg_lo;
  logic               found;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= LOW_THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    pack = PACK_W'(sample_millivolts_i) * PACK_W'(DIVIDER_RATIO);
    for (int i = 0; i < NUM_PTS; i++) begin
      hit[i] = (pack <= PACK_W'(CURVE_MV[i]));
    end
    seg_lo = '0;
    found  = 1'b0;
    for (int i = NUM_PTS - 1; i >= 1; i--) begin
      if (hit[i]) begin
        seg_lo = SEG_W'(i - 1);
        found  = 1'b1;
      end
    end
  end

  always_comb begin
    if (hit[0]) begin
      item_o.cls = CLS_ZERO;
    end else if (found) begin
      item_o.cls = CLS_INTERP;
    end else begin
      item_o.cls = CLS_FULL;
    end
    item_o.seg_lo   = seg_lo;
    item_o.delta    = DELTA_W'(pack - PACK_W'(CURVE_MV[seg_lo]));
    item_o.low_flag = reading_valid_i && (battery_level_i <= thr_q);
    item_o.status   = reading_valid_i ? STATUS_OK : STATUS_INVALID;
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

FILE: design/bsoc_queue.sv
// ----------------------------------------------------------------------------
// bsoc_queue
// Short queue of classified beats between the front and the back.
// ----------------------------------------------------------------------------
module bsoc_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bsoc_pkg::bsoc_item_t push_item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 head_valid_o,
  output bsoc_pkg::bsoc_item_t head_item_o
);
  import bsoc_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  bsoc_item_t       entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign full_o       = (count_q == CNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_item_o  = entry_q[rd_ptr_q];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("push without pop did not grow the queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> !pop_i)
    else $error("pop from empty queue");

endmodule

FILE: design/bsoc_back.sv
// ----------------------------------------------------------------------------
// bsoc_back
// Interpolates within the chosen segment, rounds half up and holds the
// result beat in the output register.
// ----------------------------------------------------------------------------
module bsoc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  bsoc_pkg::bsoc_item_t       head_item_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bsoc_pkg::PCT_W-1:0] charge_percent_o,
  output logic                       low_flag_o,
  output logic                       status_code_o
);
  import bsoc_pkg::*;

  logic              out_valid_q;
  logic [PCT_W-1:0]  pct_q, pct_d;
  logic              low_q;
  logic              status_q;
  logic              load;
  logic [SEG_W-1:0]  seg_hi;
  logic [MV_W-1:0]   span;
  logic [PCT_W-1:0]  lo_p;
  logic [PCT_W-1:0]  hi_p;
  logic [STEP_W-1:0] span_p;
  logic [NUM_W-1:0]  num;
  logic [STEP_W-1:0] quot;

  always_comb begin
    seg_hi = head_item_i.seg_lo + 1'b1;
    span   = CURVE_MV[seg_hi] - CURVE_MV[head_item_i.seg_lo];
    lo_p   = CURVE_PCT[head_item_i.seg_lo];
    hi_p   = CURVE_PCT[seg_hi];
    span_p = (hi_p >= lo_p) ? STEP_W'(hi_p - lo_p) : '0;
    num    = NUM_W'(head_item_i.delta) * NUM_W'(span_p) + NUM_W'(span >> 1);
    quot   = '0;
    for (int k = 1; k <= MAX_STEP; k++) begin
      if (num >= NUM_W'(k) * NUM_W'(span)) begin
        quot = quot + 1'b1;
      end
    end
    case (head_item_i.cls)
      CLS_ZERO:   pct_d = CURVE_PCT[0];
      CLS_FULL:   pct_d = PCT_FULL;
      CLS_INTERP: pct_d = (span == '0) ? lo_p : lo_p + PCT_W'(quot);
      default:    pct_d = PCT_FULL;
    endcase
  end

  assign load  = !out_valid_q || !out_stall_i;
  assign pop_o = head_valid_i && load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pct_q    <= pct_d;
      low_q    <= head_item_i.low_flag;
      status_q <= head_item_i.status;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign charge_percent_o = pct_q;
  assign low_flag_o       = low_q;
  assign status_code_o    = status_q;

endmodule

FILE: design/battery_soc_from_voltage.sv
// ----------------------------------------------------------------------------
// battery_soc_from_voltage
// Battery state of charge from a divided-down voltage sample.
// ----------------------------------------------------------------------------
// Takes one reading per clock while in_stall_o is low and gives one result
// beat per reading. The sample is scaled by DIVIDER_RATIO to pack voltage,
// placed on a 21-point voltage-to-percent curve and interpolated with
// half-up rounding; the low flag compares the level with the threshold
// register (reset value 1). Throughput is one beat per cycle while neither
// side stalls. The accepting edge writes a result into the two-entry queue
// and the output register loads it once it is at the queue head and the
// output is not stalled. Three readings can be held inside while the output
// is stalled. A threshold write applies to readings accepted after it.
module battery_soc_from_voltage #(
  parameter int unsigned DIVIDER_RATIO = 4,
  parameter int unsigned CURVE_POINTS  = 21
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bsoc_pkg::THR_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          reading_valid_i,
  input  logic [bsoc_pkg::LEVEL_W-1:0]  battery_level_i,
  input  logic [bsoc_pkg::SAMPLE_W-1:0] sample_millivolts_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bsoc_pkg::PCT_W-1:0]    charge_percent_o,
  output logic                          low_flag_o,
  output logic                          status_code_o
);
  import bsoc_pkg::*;

  logic       push;
  logic       full;
  logic       pop;
  logic       head_valid;
  bsoc_item_t push_item;
  bsoc_item_t head_item;

  bsoc_front #(
    .DIVIDER_RATIO (DIVIDER_RATIO),
    .CURVE_POINTS  (CURVE_POINTS)
  ) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .reading_valid_i     (reading_valid_i),
    .battery_level_i     (battery_level_i),
    .sample_millivolts_i (sample_millivolts_i),
    .full_i              (full),
    .push_o              (push),
    .item_o              (push_item)
  );

  bsoc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_item_o  (head_item)
  );

  bsoc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_item_i      (head_item),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .charge_percent_o (charge_percent_o),
    .low_flag_o       (low_flag_o),
    .status_code_o    (status_code_o)
  );

endmodule

FILE: bench/soc_reading_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// soc_reading_checker
// Watches both channels of the state of charge block, predicts each result
// beat from the accepted reading and the threshold it last saw written, and
// compares the beats field by field in order. Counts go back to the top.
// ----------------------------------------------------------------------------
module soc_reading_checker #(
  parameter int unsigned DIVIDER_RATIO = 4,
  parameter int unsigned CURVE_POINTS  = 21
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bsoc_pkg::THR_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          reading_valid_i,
  input  logic [bsoc_pkg::LEVEL_W-1:0]  battery_level_i,
  input  logic [bsoc_pkg::SAMPLE_W-1:0] sample_millivolts_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [bsoc_pkg::PCT_W-1:0]    charge_percent_i,
  input  logic                          low_flag_i,
  input  logic                          status_code_i,
  output int                            mismatch_count_o,
  output int                            pending_count_o,
  output int                            checked_count_o
);
  import bsoc_pkg::*;

  localparam int unsigned KNEE_COUNT = 21;

  typedef struct {
    logic [PCT_W-1:0] percent;
    logic             low;
    status_e          status;
  } soc_result_t;

  soc_result_t      soc_expected_q[$];
  soc_result_t      want;
  logic [THR_W-1:0] low_threshold = THR_W'(1);
  int               mismatches    = 0;
  int               checked       = 0;

  function automatic int unsigned knee_mv(input int unsigned idx);
    case (idx)
      0:  return 6000;
      1:  return 6540;
      2:  return 7220;
      3:  return 7380;
      4:  return 7420;
      5:  return 7460;
      6:  return 7500;
      7:  return 7540;
      8:  return 7580;
      9:  return 7600;
      10: return 7640;
      11: return 7700;
      12: return 7740;
      13: return 7820;
      14: return 7900;
      15: return 7960;
      16: return 8040;
      17: return 8160;
      18: return 8220;
      19: return 8300;
      default: return 8400;
    endcase
  endfunction

  // curve rises 5 percent per point
  function automatic int unsigned knee_pct(input int unsigned idx);
    return idx * 5;
  endfunction

  function automatic logic [PCT_W-1:0] soc_percent(input logic [SAMPLE_W-1:0] sample);
    int unsigned pack_mv;
    int unsigned lo_mv;
    int unsigned hi_mv;
    int unsigned lo_pct;
    int unsigned hi_pct;
    int unsigned span_pct;
    int unsigned seg_count;
    int unsigned k;
    pack_mv   = sample * DIVIDER_RATIO;
    seg_count = CURVE_POINTS;
    if (seg_count > KNEE_COUNT) seg_count = KNEE_COUNT;
    if (seg_count < 2) seg_count = 2;
    if (pack_mv <= knee_mv(0)) return PCT_W'(knee_pct(0));
    for (k = 1; k < seg_count; k++) begin
      lo_mv = knee_mv(k - 1);
      hi_mv = knee_mv(k);
      if (pack_mv <= hi_mv) begin
        lo_pct = knee_pct(k - 1);
        hi_pct = knee_pct(k);
        if (hi_mv <= lo_mv) return PCT_W'(lo_pct);
        span_pct = (hi_pct >= lo_pct) ? hi_pct - lo_pct : 0;
        return PCT_W'(lo_pct + ((pack_mv - lo_mv) * span_pct + (hi_mv - lo_mv) / 2)
                               / (hi_mv - lo_mv));
      end
    end
    return PCT_W'(100);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_threshold = THR_W'(1);
      soc_expected_q.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (soc_expected_q.size() == 0) begin
          $error("result beat with no reading waiting: charge_percent %0d", charge_percent_i);
          mismatches++;
        end else begin
          want = soc_expected_q.pop_front();
          if (charge_percent_i !== want.percent) begin
            $error("charge_percent: expected %0d, got %0d", want.percent, charge_percent_i);
            mismatches++;
          end
          if (low_flag_i !== want.low) begin
            $error("low_flag: expected %0d, got %0d", want.low, low_flag_i);
            mismatches++;
          end
          if (status_code_i !== want.status) begin
            $error("status_code: expected %0d, got %0d", want.status, status_code_i);
            mismatches++;
          end
          checked++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want.percent = soc_percent(sample_millivolts_i);
        want.low     = reading_valid_i && (battery_level_i <= low_threshold);
        want.status  = reading_valid_i ? STATUS_OK : STATUS_INVALID;
        soc_expected_q.push_back(want);
      end
      if (cfg_we_i) low_threshold = cfg_wdata_i;
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= soc_expected_q.size();
    checked_count_o  <= checked;
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the battery state of charge block: a directed
// set of readings around the curve ends and knees, then random readings in
// phases with different low thresholds, random gaps and output stalls, and
// one long output hold-off that backs the block up to its input.
// ----------------------------------------------------------------------------
module tb_top;
  import bsoc_pkg::*;

  localparam int unsigned DIVIDER_RATIO = 4;
  localparam int unsigned CURVE_POINTS  = 21;
  localparam int          PHASE_COUNT   = 5;
  localparam int          PHASE_ITEMS   = 110;
  localparam int          LONG_HOLD     = 150;
  localparam int          CYCLE_LIMIT   = 400000;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                cfg_we      = 1'b0;
  logic [THR_W-1:0]    cfg_wdata   = '0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic                reading_vld = 1'b0;
  logic [LEVEL_W-1:0]  level       = '0;
  logic [SAMPLE_W-1:0] reading_mv  = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic [PCT_W-1:0]    charge_pct;
  logic                low_flag;
  logic                status_code;

  int mismatch_count;
  int pending_count;
  int checked_count;
  int idle_pct       = 20;
  bit hold_req       = 1'b0;
  int setting_count  = 1;
  int cycle_count    = 0;

  battery_soc_from_voltage #(
    .DIVIDER_RATIO (DIVIDER_RATIO),
    .CURVE_POINTS  (CURVE_POINTS)
  ) DUT (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .reading_valid_i     (reading_vld),
    .battery_level_i     (level),
    .sample_millivolts_i (reading_mv),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .charge_percent_o    (charge_pct),
    .low_flag_o          (low_flag),
    .status_code_o       (status_code)
  );

  soc_reading_checker #(
    .DIVIDER_RATIO (DIVIDER_RATIO),
    .CURVE_POINTS  (CURVE_POINTS)
  ) u_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .reading_valid_i     (reading_vld),
    .battery_level_i     (level),
    .sample_millivolts_i (reading_mv),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .charge_percent_i    (charge_pct),
    .low_flag_i          (low_flag),
    .status_code_i       (status_code),
    .mismatch_count_o    (mismatch_count),
    .pending_count_o     (pending_count),
    .checked_count_o     (checked_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // output side: random stall bursts plus one long hold-off on request
  initial begin
    int stall_run;
    stall_run = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        stall_run = LONG_HOLD;
      end else if (stall_run == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_run = $urandom_range(1, 12);
      end
      if (stall_run > 0) begin
        out_stall <= 1'b1;
        stall_run--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_reading(input logic vld, input logic [LEVEL_W-1:0] lvl,
                              input logic [SAMPLE_W-1:0] mv);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    reading_vld <= vld;
    level       <= lvl;
    reading_mv  <= mv;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random_reading();
    logic                vld;
    logic [LEVEL_W-1:0]  lvl;
    logic [SAMPLE_W-1:0] mv;
    vld = ($urandom_range(0, 4) != 0);
    lvl = LEVEL_W'($urandom_range(0, 15));
    case ($urandom_range(0, 9))
      0:       mv = SAMPLE_W'($urandom_range(0, 65535));
      1:       mv = SAMPLE_W'($urandom_range(0, 1500));
      2:       mv = SAMPLE_W'($urandom_range(2100, 2300));
      default: mv = SAMPLE_W'($urandom_range(1490, 2110));
    endcase
    send_reading(vld, lvl, mv);
  endtask

  // the block is drained and settled before the threshold changes
  task automatic set_low_threshold(input logic [THR_W-1:0] thr);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_we    <= 1'b0;
    setting_count++;
  endtask

  initial begin
    logic [THR_W-1:0] thr;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset threshold of 1, curve ends, knees and rounding points
    send_reading(1'b1, 4'd0,  16'd0);
    send_reading(1'b1, 4'd15, 16'd1500);
    send_reading(1'b1, 4'd1,  16'd1501);
    send_reading(1'b1, 4'd2,  16'd1635);
    send_reading(1'b0, 4'd1,  16'd1805);
    send_reading(1'b1, 4'd0,  16'd1809);
    send_reading(1'b1, 4'd3,  16'd1845);
    send_reading(1'b1, 4'd1,  16'd1895);
    send_reading(1'b1, 4'd2,  16'd1901);
    send_reading(1'b1, 4'd4,  16'd1925);
    send_reading(1'b1, 4'd5,  16'd1990);
    send_reading(1'b1, 4'd6,  16'd2040);
    send_reading(1'b1, 4'd7,  16'd2075);
    send_reading(1'b1, 4'd15, 16'd2099);
    send_reading(1'b1, 4'd15, 16'd2100);
    send_reading(1'b1, 4'd0,  16'd2101);
    send_reading(1'b0, 4'd0,  16'd65535);
    send_reading(1'b1, 4'd15, 16'h8000);
    send_reading(1'b1, 4'd5,  16'h5555);
    send_reading(1'b0, 4'd10, 16'hAAAA);
    send_reading(1'b1, 4'd8,  16'h7FFF);
    send_reading(1'b0, 4'd15, 16'd1700);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0:       thr = THR_W'(0);
        1:       thr = THR_W'(15);
        default: thr = THR_W'($urandom_range(0, 15));
      endcase
      set_low_threshold(thr);
      case (phase)
        0:       idle_pct = 25;
        1:       idle_pct = 10;
        2:       idle_pct = 40;
        3:       idle_pct = 15;
        default: idle_pct = 0;
      endcase
      if (phase == 1) hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_random_reading();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("checked %0d result beats over %0d low threshold settings, 0 and 15 included",
             checked_count, setting_count);
    $display("readings spanned both curve ends, every segment and invalid flags, with gaps,");
    $display("stall bursts and a %0d cycle output hold-off", LONG_HOLD);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
